@@ hw/rtl/dssl_pkg.sv @@
// ----------------------------------------------------------------------------
// dssl_pkg: shared types and constants for the deep shadow slice lookup
// Register indexes, item kinds, RGB visibility type and default limits.
// ----------------------------------------------------------------------------
package dssl_pkg;

  localparam int unsigned DEF_MAX_IMAGE_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_BUCKET_WIDTH = 64;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;

  localparam int unsigned IMG_REG_W    = 13;
  localparam int unsigned BKT_REG_W    = 7;
  localparam int unsigned DEPTH_W      = 32;
  localparam int unsigned VIS_W        = 16;
  localparam int unsigned COL_OUT_W    = 12;

  localparam logic [IMG_REG_W-1:0] IMG_RESET = 13'd512;
  localparam logic [BKT_REG_W-1:0] BKT_RESET = 7'd16;

  // fully visible, Q1.15
  localparam logic [VIS_W-1:0] VIS_ONE = 16'h8000;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_BUCKET_WIDTH = 2'd1,
    REG_SLICE_DEPTH  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    REQ_NODE   = 1'b0,
    REQ_BUCKET = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [VIS_W-1:0] blue;
    logic [VIS_W-1:0] green;
    logic [VIS_W-1:0] red;
  } rgb_t;

  localparam int unsigned RGB_W = $bits(rgb_t);

endpackage

@@ hw/rtl/dssl_front.sv @@
// ----------------------------------------------------------------------------
// dssl_front: input side of the slice lookup
// Holds the config registers, tracks the node pairs of each function and the
// scanline column, and pushes one pixel run per last node or bucket marker.
// ----------------------------------------------------------------------------
module dssl_front import dssl_pkg::*; #(
  parameter int unsigned MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
  parameter int unsigned MAX_BUCKET_WIDTH = DEF_MAX_BUCKET_WIDTH,
  parameter int unsigned CW               = $clog2(MAX_IMAGE_WIDTH),
  parameter int unsigned BW               = $clog2(MAX_BUCKET_WIDTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_addr_i,
  input  logic [CFG_DW-1:0]  cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_type_e          in_type_i,
  input  logic [DEPTH_W-1:0] in_depth_i,
  input  rgb_t               in_vis_i,
  input  logic               in_last_i,
  // run queue write side
  input  logic               q_full_i,
  output logic               q_push_o,
  output rgb_t               q_vis_o,
  output logic [CW-1:0]      q_col_o,
  output logic [BW-1:0]      q_cnt_o
);

  localparam int unsigned EW   = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int unsigned CMPW = (EW > IMG_REG_W) ? EW : IMG_REG_W;
  localparam int unsigned SW   = EW + 1;

  logic [IMG_REG_W-1:0] img_w_q;
  logic [BKT_REG_W-1:0] bkt_w_q;
  logic [DEPTH_W-1:0]   slice_q;

  logic [CW-1:0]        col_q, col_d;
  logic                 in_fn_q, in_fn_d;
  logic                 found_q, found_d;
  logic [DEPTH_W-1:0]   prev_depth_q;
  rgb_t                 prev_vis_q, first_vis_q, chosen_vis_q;
  rgb_t                 first_vis_d, chosen_vis_d;

  logic [CMPW-1:0]      img_ext;
  logic [EW-1:0]        eff_w;
  logic [BW-1:0]        eff_b;
  logic                 accept;
  logic [CW-1:0]        col_use;
  logic [SW-1:0]        bkt_end;
  logic [EW-1:0]        px_end;
  logic                 match;
  logic                 found_now;
  rgb_t                 first_now, chosen_now;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_RESET;
      bkt_w_q <= BKT_RESET;
      slice_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i[IMG_REG_W-1:0];
        REG_BUCKET_WIDTH: bkt_w_q <= cfg_wdata_i[BKT_REG_W-1:0];
        REG_SLICE_DEPTH:  slice_q <= cfg_wdata_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp widths: zero counts as one, saturate at the limits
  always_comb begin
    img_ext = CMPW'(img_w_q);
    if (img_ext == '0) begin
      eff_w = EW'(1);
    end else if (img_ext > CMPW'(MAX_IMAGE_WIDTH)) begin
      eff_w = EW'(MAX_IMAGE_WIDTH);
    end else begin
      eff_w = EW'(img_ext);
    end
    if (bkt_w_q == '0) begin
      eff_b = BW'(1);
    end else if (bkt_w_q > BKT_REG_W'(MAX_BUCKET_WIDTH)) begin
      eff_b = BW'(MAX_BUCKET_WIDTH);
    end else begin
      eff_b = BW'(bkt_w_q);
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // column restarts if a width change left it past the row end
  assign col_use = (EW'(col_q) >= eff_w) ? '0 : col_q;
  assign bkt_end = SW'(col_use) + SW'(eff_b);
  assign px_end  = EW'(col_use) + EW'(1);

  // node pair search, including this node
  assign match      = in_fn_q && !found_q && (prev_depth_q <= slice_q) &&
                      (slice_q <= in_depth_i);
  assign found_now  = in_fn_q && (found_q || match);
  assign first_now  = in_fn_q ? first_vis_q : in_vis_i;
  assign chosen_now = match ? prev_vis_q : chosen_vis_q;

  always_comb begin
    col_d        = col_q;
    in_fn_d      = in_fn_q;
    found_d      = found_q;
    first_vis_d  = first_vis_q;
    chosen_vis_d = chosen_vis_q;
    q_push_o     = 1'b0;
    q_vis_o      = first_now;
    q_col_o      = col_use;
    q_cnt_o      = BW'(1);
    if (accept) begin
      // every accepted item settles the restarted column
      col_d = col_use;
      if (in_type_i == REQ_BUCKET) begin
        // white run, clipped at the row end
        in_fn_d  = 1'b0;
        found_d  = 1'b0;
        q_push_o = 1'b1;
        q_vis_o  = '{blue: VIS_ONE, green: VIS_ONE, red: VIS_ONE};
        q_cnt_o  = (bkt_end > SW'(eff_w)) ? BW'(eff_w - EW'(col_use)) : eff_b;
        col_d    = (bkt_end >= SW'(eff_w)) ? '0 : CW'(bkt_end);
      end else begin
        in_fn_d      = 1'b1;
        found_d      = found_now;
        first_vis_d  = first_now;
        chosen_vis_d = chosen_now;
        if (in_last_i) begin
          in_fn_d  = 1'b0;
          found_d  = 1'b0;
          q_push_o = 1'b1;
          if (in_depth_i <= slice_q) begin
            q_vis_o = in_vis_i;
          end else if (found_now) begin
            q_vis_o = chosen_now;
          end else begin
            q_vis_o = first_now;
          end
          col_d = (px_end >= eff_w) ? '0 : CW'(px_end);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      in_fn_q      <= 1'b0;
      found_q      <= 1'b0;
      prev_depth_q <= '0;
      prev_vis_q   <= '0;
      first_vis_q  <= '0;
      chosen_vis_q <= '0;
    end else begin
      col_q        <= col_d;
      in_fn_q      <= in_fn_d;
      found_q      <= found_d;
      first_vis_q  <= first_vis_d;
      chosen_vis_q <= chosen_vis_d;
      if (accept && in_type_i == REQ_NODE) begin
        prev_depth_q <= in_depth_i;
        prev_vis_q   <= in_vis_i;
      end
    end
  end

endmodule

@@ hw/rtl/dssl_queue.sv @@
// ----------------------------------------------------------------------------
// dssl_queue: short run queue between front and back
// Register FIFO of QDEPTH entries; full and empty come from a fill count.
// ----------------------------------------------------------------------------
module dssl_queue import dssl_pkg::*; #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem_q [QDEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    fill_q;

  assign full_o  = (fill_q == NW'(QDEPTH));
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + NW'(1);
        2'b01:   fill_q <= fill_q - NW'(1);
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/dssl_back.sv @@
// ----------------------------------------------------------------------------
// dssl_back: output side of the slice lookup
// Expands each queued run into pixels, scales visibility to bytes and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module dssl_back import dssl_pkg::*; #(
  parameter int unsigned CW = 12,
  parameter int unsigned BW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // run queue read side
  input  logic                 q_empty_i,
  input  rgb_t                 q_vis_i,
  input  logic [CW-1:0]        q_col_i,
  input  logic [BW-1:0]        q_cnt_i,
  output logic                 q_pop_o,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_red_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_blue_o,
  output logic [COL_OUT_W-1:0] out_col_o,
  output logic                 out_last_o
);

  logic [BW-1:0]        idx_q;
  logic                 vld_q;
  logic [7:0]           red_q, green_q, blue_q;
  logic [COL_OUT_W-1:0] col_q;
  logic                 last_q;

  logic                 advance;
  logic                 load;
  logic                 run_end;
  logic [CW-1:0]        px_col;

  // floor(v*255/32768), capped at 255
  function automatic logic [7:0] to_byte(input logic [VIS_W-1:0] v);
    logic [VIS_W+7:0] p;
    p = {v, 8'd0} - {8'd0, v};
    return p[VIS_W+7] ? 8'hFF : p[VIS_W+6:VIS_W-1];
  endfunction

  assign advance = !vld_q || out_ready_i;
  assign load    = advance && !q_empty_i;
  assign run_end = ((BW + 1)'(idx_q) + (BW + 1)'(1)) == (BW + 1)'(q_cnt_i);
  assign px_col  = q_col_i + CW'(idx_q);
  assign q_pop_o = load && run_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (advance) begin
        vld_q <= !q_empty_i;
      end
      if (load) begin
        idx_q <= run_end ? '0 : idx_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= to_byte(q_vis_i.red);
      green_q <= to_byte(q_vis_i.green);
      blue_q  <= to_byte(q_vis_i.blue);
      col_q   <= COL_OUT_W'(px_col);
      last_q  <= run_end;
    end
  end

  assign out_valid_o = vld_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_col_o   = col_q;
  assign out_last_o  = last_q;

endmodule

@@ hw/rtl/deep_shadow_slice_lookup.sv @@
// A last node or bucket marker that is accepted pushes one pixel run; a node
//   that is not last gives nothing. Throughput: one input item per cycle while
//   the queue is not full; the back end sends one pixel per cycle while not
//   stalled, and a run holds its queue slot until its last pixel is loaded.
// Reset: asynchronous, active low; clears column, function state and queue,
//   config registers return to width 512, bucket 16, slice depth 0.
// ----------------------------------------------------------------------------
// deep_shadow_slice_lookup: deep shadow map slice sampler
// Samples each pixel's visibility function at the slice depth and streams
// RGB bytes with their scanline column.
// ----------------------------------------------------------------------------
module deep_shadow_slice_lookup import dssl_pkg::*; #(
  parameter int unsigned MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
  parameter int unsigned MAX_BUCKET_WIDTH = DEF_MAX_BUCKET_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [79:0]       s_axis_tdata,  // node_depth, vis_red, vis_green, vis_blue
  input  logic              s_axis_tuser,  // req_type
  input  logic              s_axis_tlast,  // last_node
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,  // red, green, blue, column, 4 pad bits
  output logic              m_axis_tlast   // last
);

  // column counter and run length widths follow the limits
  localparam int unsigned CW  = $clog2(MAX_IMAGE_WIDTH);
  localparam int unsigned BW  = $clog2(MAX_BUCKET_WIDTH + 1);
  localparam int unsigned QW  = RGB_W + CW + BW;

  rgb_t                 in_vis;
  logic                 q_push, q_pop, q_full, q_empty;
  rgb_t                 wr_vis, rd_vis;
  logic [CW-1:0]        wr_col, rd_col;
  logic [BW-1:0]        wr_cnt, rd_cnt;
  logic [QW-1:0]        rd_word;
  logic [7:0]           red, green, blue;
  logic [COL_OUT_W-1:0] column;

  assign in_vis = '{blue:  s_axis_tdata[79:64],
                    green: s_axis_tdata[63:48],
                    red:   s_axis_tdata[47:32]};

  // front: config, function tracking, column bookkeeping
  dssl_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_BUCKET_WIDTH (MAX_BUCKET_WIDTH),
    .CW               (CW),
    .BW               (BW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_type_i   (req_type_e'(s_axis_tuser)),
    .in_depth_i  (s_axis_tdata[31:0]),
    .in_vis_i    (in_vis),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_vis_o     (wr_vis),
    .q_col_o     (wr_col),
    .q_cnt_o     (wr_cnt)
  );

  // runs of pixels: {visibility, start column, length}
  dssl_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({wr_vis, wr_col, wr_cnt}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rd_word),
    .empty_o (q_empty)
  );

  assign {rd_vis, rd_col, rd_cnt} = rd_word;

  // back: one pixel per cycle into the output register while not stalled
  dssl_back #(
    .CW (CW),
    .BW (BW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_vis_i     (rd_vis),
    .q_col_i     (rd_col),
    .q_cnt_i     (rd_cnt),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_red_o   (red),
    .out_green_o (green),
    .out_blue_o  (blue),
    .out_col_o   (column),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, column, blue, green, red};

endmodule

@@ hw/rtl/dssl_checker.sv @@
// ----------------------------------------------------------------------------
// dssl_checker: port-level checks for the slice lookup
// Watches the result stream for stall stability, run continuity and reset.
// ----------------------------------------------------------------------------
module dssl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic        acc;
  logic        prev_last_q;
  logic [11:0] prev_col_q;

  assign acc = m_axis_tvalid && m_axis_tready;

  // last accepted pixel, to follow runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
      prev_col_q  <= '0;
    end else if (acc) begin
      prev_last_q <= m_axis_tlast;
      prev_col_q  <= m_axis_tdata[35:24];
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_run_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !prev_last_q |-> m_axis_tdata[35:24] == prev_col_q + 12'd1)
    else $error("pixel run skipped a column");

  a_run_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !m_axis_tlast |-> m_axis_tdata[23:0] == 24'hFFFFFF)
    else $error("non-final pixel of a run is not white");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid coming out of reset");

endmodule

bind deep_shadow_slice_lookup dssl_checker u_dssl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
